### design/bzease_pkg.sv
// Shared types and constants for the cubic Bezier easing bisection block.
// Holds the datapath command and status words and the field widths.
// Depends on nothing; every other design file imports it.
`default_nettype none

package bzease_pkg;

	// Field widths of the stream words and the configuration registers.
	localparam int XPOS_W    = 17;
	localparam int CTRL_W    = 7;
	localparam int YOUT_W    = 17;
	localparam int TOL_W     = 16;
	localparam int ITER_W    = 7;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 24;
	localparam int CFG_IDX_W = 1;

	// Default number of fraction bits inside the datapath.
	localparam int FRAC_BITS_DEF = 16;

	// Register indexes on the configuration port and their reset values.
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'b1;
	localparam logic [TOL_W-1:0]     TOL_RST       = 16'd7;
	localparam logic [ITER_W-1:0]    MAX_ITER_RST  = 7'd100;

	// Operations the controller asks of the datapath, one per cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SETU,
		OP_T2,
		OP_T3,
		OP_U2,
		OP_W1,
		OP_W2,
		OP_M1,
		OP_M2,
		OP_SUM,
		OP_DIV,
		OP_ERR,
		OP_STEP,
		OP_OUT
	} dp_op_t;

	// Command word from the controller.
	typedef struct packed {
		dp_op_t op;
		logic   sel_y;
	} dp_cmd_t;

	// Status word back to the controller.
	typedef struct packed {
		logic div_busy;
		logic tol_met;
	} dp_sts_t;

endpackage

`default_nettype wire

### design/bzease_dp.sv
// Datapath of the Bezier easing solver: one shared multiplier, the Bezier
// term registers, a fold-based divide by 127 and the bisection bounds.
// Depends on bzease_pkg; driven by commands from bzease_ctrl.
`default_nettype none

module bzease_dp #(
	parameter int FRAC_BITS = bzease_pkg::FRAC_BITS_DEF
) (
	input  wire                              clk,
	input  wire bzease_pkg::dp_cmd_t         cmd,
	output bzease_pkg::dp_sts_t              sts,
	input  wire [bzease_pkg::XPOS_W-1:0]     x_pos,
	input  wire [bzease_pkg::CTRL_W-1:0]     ctrl_x1,
	input  wire [bzease_pkg::CTRL_W-1:0]     ctrl_y1,
	input  wire [bzease_pkg::CTRL_W-1:0]     ctrl_x2,
	input  wire [bzease_pkg::CTRL_W-1:0]     ctrl_y2,
	input  wire [bzease_pkg::TOL_W-1:0]      tolerance,
	output logic [bzease_pkg::YOUT_W-1:0]    y_out,
	output logic                             converged
);
	import bzease_pkg::*;

	// Widths: t-like values reach ONE, weights reach about 3*ONE.
	localparam int TW  = FRAC_BITS + 1;
	localparam int WW  = FRAC_BITS + 2;
	localparam int AW  = FRAC_BITS + 3;
	localparam int PW  = AW + TW;
	localparam int MW  = WW + CTRL_W;
	localparam int SW  = FRAC_BITS + 11;
	localparam int HW  = SW - 7;
	localparam int T3W = TW + 7;
	localparam int EW  = FRAC_BITS + 3;
	localparam int CW  = EW + 16;
	localparam int XSW = XPOS_W + FRAC_BITS;
	localparam int YSW = TW + 16;
	localparam logic [TW-1:0] ONE_T  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [TW-1:0] HALF_T = {2'b01, {(FRAC_BITS - 1){1'b0}}};

	logic [TW-1:0]          xt_q, lo_q, mid_q, hi_q;
	logic [TW-1:0]          u_q, t2_q, t3_q, u2_q, quot_q;
	logic [WW-1:0]          w1_q, w2_q;
	logic [T3W-1:0]         t3s_q;
	logic [MW-1:0]          m2_q;
	logic [SW-1:0]          acc_q;
	logic signed [EW-1:0]   el_q, em_q;
	logic                   conv_q;
	logic [CTRL_W-1:0]      px1_q, py1_q, px2_q, py2_q;
	logic [YOUT_W-1:0]      yout_q;
	logic                   convout_q;

	logic [AW-1:0]          mul_a;
	logic [TW-1:0]          mul_b;
	logic [PW-1:0]          prod, prod_sh;
	logic [CTRL_W-1:0]      p1, p2;
	logic [HW-1:0]          acc_hi;
	logic [TW-1:0]          b_fin;
	logic [XSW-1:0]         xs, xs_sh;
	logic [TW-1:0]          target;
	logic [EW-1:0]          mag;
	logic [CW-1:0]          err_scaled, tol_scaled;
	logic                   tol_met;
	logic                   el_neg, el_pos, em_neg, em_pos, opposite;
	logic [TW:0]            mid_lo_sum, hi_mid_sum;
	logic [YSW-1:0]         ys;

	// Control bytes of the coordinate being evaluated.
	assign p1 = cmd.sel_y ? py1_q : px1_q;
	assign p2 = cmd.sel_y ? py2_q : px2_q;

	// Target x rescaled from Q1.16 to the internal fraction width.
	assign xs     = {x_pos, {FRAC_BITS{1'b0}}};
	assign xs_sh  = xs >> 16;
	assign target = xs_sh[TW-1:0];

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (cmd.op)
			OP_T2: begin
				mul_a = AW'(mid_q);
				mul_b = mid_q;
			end
			OP_T3: begin
				mul_a = AW'(t2_q);
				mul_b = mid_q;
			end
			OP_U2: begin
				mul_a = AW'(u_q);
				mul_b = u_q;
			end
			OP_W1: begin
				mul_a = AW'(u2_q) + (AW'(u2_q) << 1);
				mul_b = mid_q;
			end
			OP_W2: begin
				mul_a = AW'(u_q) + (AW'(u_q) << 1);
				mul_b = t2_q;
			end
			OP_M1: begin
				mul_a = AW'(w1_q);
				mul_b = TW'(p1);
			end
			OP_M2: begin
				mul_a = AW'(w2_q);
				mul_b = TW'(p2);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = PW'(mul_a) * PW'(mul_b);
	assign prod_sh = prod >> FRAC_BITS;

	// Divide by 127: fold the bits above seven back onto the low seven.
	assign acc_hi = acc_q[SW-1:7];
	assign b_fin  = quot_q + TW'(acc_q[6:0] == 7'h7f);

	// Tolerance test on the midpoint error.
	assign mag        = em_q[EW-1] ? (~em_q + EW'(1)) : em_q;
	assign err_scaled = {mag, 16'h0000};
	assign tol_scaled = CW'({tolerance, {FRAC_BITS{1'b0}}});
	assign tol_met    = err_scaled < tol_scaled;

	// Sign comparison of the errors at the low bound and the midpoint.
	assign el_neg   = el_q[EW-1];
	assign el_pos   = !el_q[EW-1] && (el_q != '0);
	assign em_neg   = em_q[EW-1];
	assign em_pos   = !em_q[EW-1] && (em_q != '0);
	assign opposite = (el_neg && em_pos) || (el_pos && em_neg);

	assign mid_lo_sum = {1'b0, mid_q} + {1'b0, lo_q};
	assign hi_mid_sum = {1'b0, hi_q} + {1'b0, mid_q};

	// Output rescaled from the internal fraction width to Q1.16.
	assign ys = {b_fin, 16'h0000} >> FRAC_BITS;

	// Register updates, one operation per cycle.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				xt_q   <= target;
				lo_q   <= '0;
				mid_q  <= HALF_T;
				hi_q   <= ONE_T;
				el_q   <= EW'(target);
				conv_q <= 1'b0;
				px1_q  <= ctrl_x1;
				py1_q  <= ctrl_y1;
				px2_q  <= ctrl_x2;
				py2_q  <= ctrl_y2;
			end
			OP_SETU: begin
				u_q <= ONE_T - mid_q;
			end
			OP_T2: begin
				t2_q <= prod_sh[TW-1:0];
			end
			OP_T3: begin
				t3_q <= prod_sh[TW-1:0];
			end
			OP_U2: begin
				u2_q  <= prod_sh[TW-1:0];
				t3s_q <= {t3_q, 7'h00} - T3W'(t3_q);
			end
			OP_W1: begin
				w1_q <= prod_sh[WW-1:0];
			end
			OP_W2: begin
				w2_q <= prod_sh[WW-1:0];
			end
			OP_M1: begin
				acc_q <= SW'(prod[MW-1:0]);
			end
			OP_M2: begin
				m2_q <= prod[MW-1:0];
			end
			OP_SUM: begin
				acc_q  <= acc_q + SW'(m2_q) + SW'(t3s_q);
				quot_q <= '0;
			end
			OP_DIV: begin
				if (acc_hi != '0) begin
					quot_q <= quot_q + TW'(acc_hi);
					acc_q  <= SW'(acc_hi) + SW'(acc_q[6:0]);
				end
			end
			OP_ERR: begin
				em_q <= EW'(xt_q) - EW'(b_fin);
			end
			OP_STEP: begin
				if (tol_met) begin
					conv_q <= 1'b1;
				end else if (opposite) begin
					hi_q  <= mid_q;
					mid_q <= mid_lo_sum[TW:1];
				end else begin
					lo_q  <= mid_q;
					mid_q <= hi_mid_sum[TW:1];
					el_q  <= em_q;
				end
			end
			OP_OUT: begin
				yout_q    <= ys[YOUT_W-1:0];
				convout_q <= conv_q;
			end
			default: begin
			end
		endcase
	end

	assign sts.div_busy = acc_hi != '0;
	assign sts.tol_met  = tol_met;
	assign y_out        = yout_q;
	assign converged    = convout_q;

endmodule

`default_nettype wire

### design/bzease_ctrl.sv
// Controller of the Bezier easing solver: sequences the curve evaluation,
// the bisection steps and the output word handshake.
// Depends on bzease_pkg; commands bzease_dp.
`default_nettype none

module bzease_ctrl (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	input  wire [bzease_pkg::ITER_W-1:0]    max_iterations,
	input  wire bzease_pkg::dp_sts_t        sts,
	output bzease_pkg::dp_cmd_t             cmd
);
	import bzease_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE  = 15'h0001,
		S_CHECK = 15'h0002,
		S_SETU  = 15'h0004,
		S_T2    = 15'h0008,
		S_T3    = 15'h0010,
		S_U2    = 15'h0020,
		S_W1    = 15'h0040,
		S_W2    = 15'h0080,
		S_M1    = 15'h0100,
		S_M2    = 15'h0200,
		S_SUM   = 15'h0400,
		S_DIV   = 15'h0800,
		S_ERR   = 15'h1000,
		S_STEP  = 15'h2000,
		S_FIN   = 15'h4000
	} state_t;

	state_t              state_q, state_nxt;
	dp_op_t              op;
	logic [ITER_W-1:0]   iter_q;
	logic                sel_y_q;
	logic                m_valid_q;

	// Next state and the datapath operation of the current state.
	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		s_tready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					op        = OP_LOAD;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				state_nxt = S_SETU;
			end
			S_SETU: begin
				op        = OP_SETU;
				state_nxt = S_T2;
			end
			S_T2: begin
				op        = OP_T2;
				state_nxt = S_T3;
			end
			S_T3: begin
				op        = OP_T3;
				state_nxt = S_U2;
			end
			S_U2: begin
				op        = OP_U2;
				state_nxt = S_W1;
			end
			S_W1: begin
				op        = OP_W1;
				state_nxt = S_W2;
			end
			S_W2: begin
				op        = OP_W2;
				state_nxt = S_M1;
			end
			S_M1: begin
				op        = OP_M1;
				state_nxt = S_M2;
			end
			S_M2: begin
				op        = OP_M2;
				state_nxt = S_SUM;
			end
			S_SUM: begin
				op        = OP_SUM;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				op = OP_DIV;
				if (!sts.div_busy) begin
					state_nxt = sel_y_q ? S_FIN : S_ERR;
				end
			end
			S_ERR: begin
				op        = OP_ERR;
				state_nxt = S_STEP;
			end
			S_STEP: begin
				op        = OP_STEP;
				state_nxt = sts.tol_met ? S_SETU : S_CHECK;
			end
			S_FIN: begin
				if (!m_valid_q || m_tready) begin
					op        = OP_OUT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State, step counter, coordinate select and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			iter_q    <= '0;
			sel_y_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (op == OP_LOAD) begin
				iter_q  <= '0;
				sel_y_q <= 1'b0;
			end else if (state_q == S_CHECK && iter_q == max_iterations) begin
				sel_y_q <= 1'b1;
			end else if (op == OP_STEP) begin
				if (sts.tol_met) begin
					sel_y_q <= 1'b1;
				end else begin
					iter_q <= iter_q + ITER_W'(1);
				end
			end
			if (op == OP_OUT) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid  = m_valid_q;
	assign cmd.op    = op;
	assign cmd.sel_y = sel_y_q;

endmodule

`default_nettype wire

### design/bezier_easing_bisection_top.sv
// Cubic Bezier easing by bisection: each bisection step (at most max_iterations) runs the
// curve evaluation through the one shared multiplier, a divide by 127 that folds until
// nothing is left above bit seven, the error and the step; a final evaluation gives y.
// One item at a time; the next item is taken while the result word waits. Reset (async,
// active low) empties the block and sets tolerance 7 and max_iterations 100.
`default_nettype none

module bezier_easing_bisection_top #(
	parameter int FRAC_BITS = bzease_pkg::FRAC_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// Fields from bit 0: x_pos[16:0], ctrl_x1[23:17], ctrl_y1[30:24],
	// ctrl_x2[37:31], ctrl_y2[44:38], zero fill.
	input  wire [bzease_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// Fields from bit 0: y_out[16:0], converged[17], zero fill.
	output logic [bzease_pkg::M_TDATA_W-1:0]   m_tdata,
	input  wire                                cfg_we,
	input  wire [bzease_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [bzease_pkg::TOL_W-1:0]        cfg_wdata
);
	import bzease_pkg::*;

	logic [TOL_W-1:0]    tolerance_q;
	logic [ITER_W-1:0]   max_iter_q;
	dp_cmd_t             cmd;
	dp_sts_t             sts;
	logic [YOUT_W-1:0]   y_out;
	logic                converged;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RST;
			max_iter_q  <= MAX_ITER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOLERANCE: tolerance_q <= cfg_wdata;
				REG_MAX_ITER:  max_iter_q  <= cfg_wdata[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bzease_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.max_iterations (max_iter_q),
		.sts            (sts),
		.cmd            (cmd)
	);

	bzease_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.sts       (sts),
		.x_pos     (s_tdata[16:0]),
		.ctrl_x1   (s_tdata[23:17]),
		.ctrl_y1   (s_tdata[30:24]),
		.ctrl_x2   (s_tdata[37:31]),
		.ctrl_y2   (s_tdata[44:38]),
		.tolerance (tolerance_q),
		.y_out     (y_out),
		.converged (converged)
	);

	// Result word.
	assign m_tdata = {6'b000000, converged, y_out};

endmodule

`default_nettype wire
